// ===== design/itp_pkg.sv =====
// Shared types, constants and helper functions for the infix-to-postfix converter.
// No dependencies.
package itp_pkg;

  localparam int CHAR_W          = 8;
  localparam int STACK_DEPTH_DEF = 32;
  localparam int PREC_W          = 2;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RPAR,
    ST_OPS,
    ST_FLUSH
  } itp_state_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CHAR_W-1:0] din;
  } itp_stack_ctl_t;

  function automatic logic [PREC_W-1:0] prec_of(input logic [CHAR_W-1:0] c);
    logic [PREC_W-1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    else if (c == CH_MUL || c == CH_DIV) p = 2'd2;
    else if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

// ===== design/itp_cell.sv =====
// One stack entry: shifts down on push, up on pop.
// Depends on itp_pkg.
module itp_cell import itp_pkg::*; (
  input  logic              clk,
  input  itp_stack_ctl_t    ctl,
  input  logic [CHAR_W-1:0] from_above,
  input  logic [CHAR_W-1:0] from_below,
  output logic [CHAR_W-1:0] q
);

  logic [CHAR_W-1:0] data_r;
  logic [CHAR_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.push) begin
      data_nxt = from_above;
    end else if (ctl.pop) begin
      data_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== design/itp_stack.sv =====
// Operator stack as a chain of shift cells; cell 0 holds the top.
// Depends on itp_pkg and itp_cell.
module itp_stack import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  itp_stack_ctl_t    ctl,
  output logic [CHAR_W-1:0] top,
  output logic [CHAR_W-1:0] second
);

  logic [CHAR_W-1:0] q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [CHAR_W-1:0] above;
    logic [CHAR_W-1:0] below;
    if (i == 0) begin : g_first
      assign above = ctl.din;
    end else begin : g_mid
      assign above = q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = CH_NUL;
    end else begin : g_rest
      assign below = q[i+1];
    end
    itp_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_above(above),
      .from_below(below),
      .q         (q[i])
    );
  end

  assign top    = q[0];
  assign second = q[1];

endmodule

// ===== design/infix_to_postfix_converter.sv =====
// Infix-to-postfix converter (shunting-yard) on a chain of stack cells.
// Latency: a letter or digit is on the output in the cycle after it is taken.
// Input is taken only while idle and the output can advance; it is held off while operators are popped,
// for every operator's push, every closing paren's discard or empty-stack exit, and the end terminator.
// Reset clears the fill count, state and output valid; cell contents are not cleared.
module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_symbol,
  input  logic              in_end_of_expr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last_of_run,
  output logic              out_expr_done
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  itp_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CHAR_W-1:0] sym_r, sym_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_done_r, out_done_nxt;

  itp_stack_ctl_t    ctl;
  logic [CHAR_W-1:0] top, second;
  logic              emit_ok, full, empty, one_left, accept;

  itp_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .ctl   (ctl),
    .top   (top),
    .second(second)
  );

  assign emit_ok  = !out_valid_r || out_ready;
  assign full     = (count_r == CNT_W'(STACK_DEPTH));
  assign empty    = (count_r == '0);
  assign one_left = (count_r == CNT_W'(1));
  assign in_ready = (state_r == ST_IDLE) && emit_ok;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    sym_nxt       = sym_r;
    ctl.push      = 1'b0;
    ctl.pop       = 1'b0;
    ctl.din       = in_symbol;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_end_of_expr) begin
            state_nxt = ST_FLUSH;
          end else if (is_alnum(in_symbol)) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = in_symbol;
            out_last_nxt  = 1'b1;
            out_done_nxt  = 1'b0;
          end else if (in_symbol == CH_LPAR) begin
            ctl.push = !full;
          end else if (in_symbol == CH_RPAR) begin
            state_nxt = ST_RPAR;
          end else begin
            sym_nxt   = in_symbol;
            state_nxt = ST_OPS;
          end
        end
      end
      ST_RPAR: begin
        priority if (empty) begin
          state_nxt = ST_IDLE;
        end else if (top == CH_LPAR) begin
          ctl.pop   = 1'b1;
          state_nxt = ST_IDLE;
        end else if (emit_ok) begin
          ctl.pop       = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = top;
          out_last_nxt  = one_left || (second == CH_LPAR);
          out_done_nxt  = 1'b0;
        end
      end
      ST_OPS: begin
        priority if (empty || prec_of(top) < prec_of(sym_r)) begin
          ctl.din   = sym_r;
          ctl.push  = !full;
          state_nxt = ST_IDLE;
        end else if (emit_ok) begin
          ctl.pop       = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = top;
          out_last_nxt  = one_left || (prec_of(second) < prec_of(sym_r));
          out_done_nxt  = 1'b0;
        end
      end
      ST_FLUSH: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          if (empty) begin
            out_char_nxt = CH_NUL;
            out_last_nxt = 1'b1;
            out_done_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            ctl.pop      = 1'b1;
            out_char_nxt = top;
            out_last_nxt = 1'b0;
            out_done_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;
  assign out_expr_done   = out_done_r;

endmodule
